>>> rtl/timeslot_admission_queue_macros.svh
// Assertion macros shared by the timeslot admission queue RTL.
// Each macro expects a clock named clk and a synchronous reset named rst in scope.
`ifndef TIMESLOT_ADMISSION_QUEUE_MACROS_SVH
`define TIMESLOT_ADMISSION_QUEUE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TSAQ_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TSAQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/tsaq_pkg.sv
// Types, codes and constants of the timeslot admission queue.
// Has no dependencies; used by every module of the block.
package tsaq_pkg;

  localparam int DEPTH_DEFAULT = 8;

  // The tick counter wraps at 2**START_W.
  localparam int START_W = 24;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 24;
  localparam int LIMIT_W = 4;

  // Microsecond to tick conversion, ticks = floor(us * 32768 / 1000000), is done as
  // ticks = (us * TICK_RECIP) >> RECIP_SHIFT. TICK_RECIP is 2**56 / 15625 rounded up, and its
  // rounding error stays below one tick for every input of US_W bits.
  localparam int US_W = 33;
  localparam int TICKS_W = 30;
  localparam int RECIP_W = 43;
  localparam int RECIP_LO_W = 22;
  localparam int RECIP_SHIFT = 47;
  localparam logic [RECIP_W-1:0] TICK_RECIP = 43'd4611686018428;
  localparam int PROD_W = US_W + RECIP_LO_W;
  localparam int ACC_W = RECIP_SHIFT + TICKS_W;

  localparam logic REQ_APPEND = 1'b0;
  localparam logic REQ_REMOVE = 1'b1;

  localparam logic [1:0] STATUS_OK = 2'd0;
  localparam logic [1:0] STATUS_FULL = 2'd1;
  localparam logic [1:0] STATUS_PEER_LIMIT = 2'd2;
  localparam logic [1:0] STATUS_TOO_CLOSE = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_RANGING_OFFSET = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_GAP = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PEER_LIMIT = 2'd2;

  typedef struct packed {
    logic         req_type;
    logic [47:0]  peer_addr;
    logic [7:0]   peer_addr_type;
    logic [31:0]  delay_us;
    logic [23:0]  ref_tick;
    logic [31:0]  window_us;
    logic [31:0]  slot_len_us;
    logic [31:0]  seed_in;
  } req_t;

  typedef struct packed {
    logic [1:0]   status;
    logic [31:0]  seed_out;
    logic         head_valid;
    logic [23:0]  head_start;
    logic [31:0]  head_slot_len;
    logic [31:0]  head_window_len;
    logic [47:0]  head_peer_addr;
    logic [7:0]   head_peer_type;
    logic [31:0]  head_seed;
  } rsp_t;

  typedef struct packed {
    logic [START_W-1:0] start;
    logic [31:0]        slot_len;
    logic [31:0]        window_len;
    logic [55:0]        peer;
    logic [31:0]        seed;
  } entry_t;

endpackage

>>> rtl/tsaq_mem.sv
// Entry store of the timeslot admission queue: one write port, one registered read port.
// Depends on tsaq_pkg for the entry type.
module tsaq_mem #(
  parameter int DEPTH = tsaq_pkg::DEPTH_DEFAULT,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  tsaq_pkg::entry_t  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output tsaq_pkg::entry_t  rd_data
);
  import tsaq_pkg::*;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/tsaq_tick_conv.sv
// Microsecond to tick converter, a multiplication by a scaled reciprocal.
// Depends on tsaq_pkg for widths and the reciprocal.
module tsaq_tick_conv (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [tsaq_pkg::US_W-1:0]    us,
  output logic                         busy,
  output logic [tsaq_pkg::TICKS_W-1:0] ticks
);
  import tsaq_pkg::*;

  logic [US_W-1:0]       us_q;
  logic                  phase;
  logic [ACC_W-1:0]      acc;
  logic [RECIP_LO_W-1:0] factor;
  logic [PROD_W-1:0]     partial;

  // One multiplier takes the low half of the reciprocal first and the high half second.
  always_comb begin
    if (phase) begin
      factor = RECIP_LO_W'(TICK_RECIP[RECIP_W-1:RECIP_LO_W]);
    end else begin
      factor = TICK_RECIP[RECIP_LO_W-1:0];
    end
    partial = PROD_W'(us_q) * PROD_W'(factor);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      phase <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      phase <= 1'b0;
    end else if (busy) begin
      phase <= 1'b1;
      if (phase) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      us_q <= us;
    end else if (busy) begin
      if (phase) begin
        acc <= acc + (ACC_W'(partial) << RECIP_LO_W);
      end else begin
        acc <= ACC_W'(partial);
      end
    end
  end

  assign ticks = acc[ACC_W-1:RECIP_SHIFT];

endmodule

>>> rtl/timeslot_admission_queue.sv
// A bounded FIFO of ranging timeslot requests with admission control. Requests are handled one
// at a time, and each gives one result. A remove, or an append refused because the queue is
// full, goes straight to the head read and the output. An append to an empty queue runs the
// tick conversion and writes the entry. An append to a queue holding entries reads the entries
// one per cycle from the entry store for the peer count, with the first tick conversion running
// underneath, and then, unless refused for the peer limit, converts the tail slot length plus
// gap to check the spacing before the write. A finished result waits in the output register
// while the next transaction is accepted. Configuration writes are always ready; the user must
// make them only while nothing is in flight, which the block itself does not enforce.
`include "timeslot_admission_queue_macros.svh"

module timeslot_admission_queue #(
  parameter int QUEUE_DEPTH = tsaq_pkg::DEPTH_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           req_valid,
  output logic                           req_stall,
  input  tsaq_pkg::req_t                 req,
  output logic                           rsp_valid,
  input  logic                           rsp_stall,
  output tsaq_pkg::rsp_t                 rsp,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [tsaq_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tsaq_pkg::CFG_DATA_W-1:0] cfg_data
);
  import tsaq_pkg::*;

  localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;
  localparam int CMP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_WALK = 3'd1;
  localparam logic [2:0] ST_DIV1 = 3'd2;
  localparam logic [2:0] ST_DIV2 = 3'd3;
  localparam logic [2:0] ST_WRITE = 3'd4;
  localparam logic [2:0] ST_HEAD_RD = 3'd5;
  localparam logic [2:0] ST_OUT = 3'd6;

  function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] base,
                                                 input logic [CNT_W-1:0] k);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(base) + SUM_W'(k);
    if (sum >= SUM_W'(QUEUE_DEPTH)) begin
      sum = sum - SUM_W'(QUEUE_DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

  logic [2:0]         state;
  req_t               req_q;
  logic [1:0]         res_status;
  logic [31:0]        res_seed;
  logic [IDX_W-1:0]   head;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   rd_k;
  logic [CNT_W-1:0]   same;
  logic               rd_pending;
  logic               rd_last;
  logic [START_W-1:0] new_start;
  logic [START_W-1:0] tail_start;
  logic [31:0]        tail_slot;

  logic [CFG_DATA_W-1:0] ranging_offset;
  logic [CFG_DATA_W-1:0] min_gap;
  logic [LIMIT_W-1:0]    peer_limit;

  logic               walk_issue;
  logic               mem_wr;
  logic               mem_rd;
  logic [IDX_W-1:0]   mem_rd_addr;
  entry_t             wr_entry;
  entry_t             rd_entry;
  logic               div_start;
  logic [US_W-1:0]    div_us;
  logic               div_busy;
  logic [TICKS_W-1:0] ticks;
  logic [START_W-1:0] spacing;
  logic               req_accept;

  assign cfg_ready = 1'b1;
  assign req_stall = (state != ST_IDLE);
  assign req_accept = req_valid && !req_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      ranging_offset <= '0;
      min_gap <= '0;
      peer_limit <= LIMIT_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_RANGING_OFFSET: ranging_offset <= cfg_data;
        CFG_MIN_GAP:        min_gap <= cfg_data;
        CFG_PEER_LIMIT:     peer_limit <= cfg_data[LIMIT_W-1:0];
        default:            ;
      endcase
    end
  end

  assign walk_issue = (state == ST_WALK) && (rd_k < count);
  assign mem_rd = walk_issue || (state == ST_HEAD_RD);
  assign mem_rd_addr = (state == ST_HEAD_RD) ? head : wrap_add(head, rd_k);
  assign mem_wr = (state == ST_WRITE);
  assign spacing = new_start - tail_start;

  always_comb begin
    wr_entry.start = new_start;
    wr_entry.slot_len = req_q.slot_len_us;
    wr_entry.window_len = req_q.window_us;
    wr_entry.peer = {req_q.peer_addr_type, req_q.peer_addr};
    wr_entry.seed = req_q.seed_in + 32'd1;
  end

  always_comb begin
    div_start = 1'b0;
    div_us = US_W'(req.delay_us) + US_W'(ranging_offset);
    if (req_accept && req.req_type == REQ_APPEND && count != CNT_W'(QUEUE_DEPTH)) begin
      div_start = 1'b1;
    end else if (state == ST_DIV1 && !div_busy && count != '0
                 && CMP_W'(same) < CMP_W'(peer_limit)) begin
      div_start = 1'b1;
      div_us = US_W'(tail_slot) + US_W'(min_gap);
    end
  end

  tsaq_mem #(
    .DEPTH  (QUEUE_DEPTH),
    .ADDR_W (IDX_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr),
    .wr_addr (wrap_add(head, count)),
    .wr_data (wr_entry),
    .rd_en   (mem_rd),
    .rd_addr (mem_rd_addr),
    .rd_data (rd_entry)
  );

  tsaq_tick_conv u_conv (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .us    (div_us),
    .busy  (div_busy),
    .ticks (ticks)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      head <= '0;
      count <= '0;
      rd_pending <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (state == ST_OUT && (!rsp_valid || !rsp_stall)) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      rd_pending <= walk_issue;
      unique case (state)
        ST_IDLE: begin
          if (req_accept) begin
            if (req.req_type == REQ_REMOVE) begin
              if (count != '0) begin
                head <= wrap_add(head, CNT_W'(1));
                count <= count - 1'b1;
              end
              state <= ST_HEAD_RD;
            end else if (count == CNT_W'(QUEUE_DEPTH)) begin
              state <= ST_HEAD_RD;
            end else if (count == '0) begin
              state <= ST_DIV1;
            end else begin
              state <= ST_WALK;
            end
          end
        end
        ST_WALK: begin
          if (rd_pending && rd_last) begin
            state <= ST_DIV1;
          end
        end
        ST_DIV1: begin
          if (!div_busy) begin
            if (count == '0) begin
              state <= ST_WRITE;
            end else if (CMP_W'(same) >= CMP_W'(peer_limit)) begin
              state <= ST_HEAD_RD;
            end else begin
              state <= ST_DIV2;
            end
          end
        end
        ST_DIV2: begin
          if (!div_busy) begin
            state <= (TICKS_W'(spacing) < ticks) ? ST_HEAD_RD : ST_WRITE;
          end
        end
        ST_WRITE: begin
          count <= count + 1'b1;
          state <= ST_HEAD_RD;
        end
        ST_HEAD_RD: begin
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (!rsp_valid || !rsp_stall) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (req_accept) begin
      req_q <= req;
      res_seed <= req.seed_in;
      res_status <= (req.req_type == REQ_APPEND && count == CNT_W'(QUEUE_DEPTH))
                    ? STATUS_FULL : STATUS_OK;
      rd_k <= '0;
      same <= '0;
    end
    if (walk_issue) begin
      rd_k <= rd_k + 1'b1;
      rd_last <= (rd_k == count - 1'b1);
    end
    if (state == ST_WALK && rd_pending) begin
      if (rd_entry.peer == {req_q.peer_addr_type, req_q.peer_addr}) begin
        same <= same + 1'b1;
      end
      if (rd_last) begin
        tail_start <= rd_entry.start;
        tail_slot <= rd_entry.slot_len;
      end
    end
    if (state == ST_DIV1 && !div_busy) begin
      new_start <= req_q.ref_tick + ticks[START_W-1:0];
      if (count != '0 && CMP_W'(same) >= CMP_W'(peer_limit)) begin
        res_status <= STATUS_PEER_LIMIT;
      end
    end
    if (state == ST_DIV2 && !div_busy && TICKS_W'(spacing) < ticks) begin
      res_status <= STATUS_TOO_CLOSE;
    end
    if (state == ST_WRITE) begin
      res_seed <= req_q.seed_in + 32'd1;
    end
    if (state == ST_OUT && (!rsp_valid || !rsp_stall)) begin
      rsp.status <= res_status;
      rsp.seed_out <= res_seed;
      rsp.head_valid <= (count != '0);
      if (count != '0) begin
        rsp.head_start <= rd_entry.start;
        rsp.head_slot_len <= rd_entry.slot_len;
        rsp.head_window_len <= rd_entry.window_len;
        rsp.head_peer_addr <= rd_entry.peer[47:0];
        rsp.head_peer_type <= rd_entry.peer[55:48];
        rsp.head_seed <= rd_entry.seed;
      end else begin
        rsp.head_start <= '0;
        rsp.head_slot_len <= '0;
        rsp.head_window_len <= '0;
        rsp.head_peer_addr <= '0;
        rsp.head_peer_type <= '0;
        rsp.head_seed <= '0;
      end
    end
  end

  `TSAQ_ASSERT_IMP(a_count_in_range, 1'b1, count <= CNT_W'(QUEUE_DEPTH), "count above depth")
  `TSAQ_ASSERT_IMP(a_write_not_full, mem_wr, count < CNT_W'(QUEUE_DEPTH), "write to full queue")
  `TSAQ_ASSERT_NEXT(a_write_grows, mem_wr, count == $past(count) + 1'b1, "count not advanced")
  `TSAQ_ASSERT_IMP(a_conv_idle_start, div_start, !div_busy, "converter restarted while busy")
  `TSAQ_ASSERT_IMP(a_empty_head_zero, rsp_valid && !rsp.head_valid,
                   rsp.head_start == '0 && rsp.head_seed == '0, "empty head not cleared")

endmodule

>>> bench/tb_top.sv
// Self-checking testbench for the timeslot admission queue: a directed table, then random
// phases over several register settings, each response checked against the table's expected
// value or an in-bench predictor. Depends only on tsaq_pkg and the timeslot_admission_queue RTL.
`timescale 1ns / 1ps

module tb_top;
  import tsaq_pkg::*;

  localparam int DEPTH = DEPTH_DEFAULT;
  localparam int QUIET_LIMIT = 2000;
  localparam int PHASES = 7;
  localparam int PHASE_ITEMS = 200;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef struct {
    req_t stim;
    bit   typed;
    rsp_t want;
  } plan_row_t;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  req_valid = 1'b0;
  logic                  req_stall;
  req_t                  req = '0;
  logic                  rsp_valid;
  logic                  rsp_stall = 1'b0;
  rsp_t                  rsp;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  entry_t      slots [DEPTH];
  int          head_pos = 0;
  int          occupancy = 0;
  logic [23:0] reg_offset = '0;
  logic [23:0] reg_gap = '0;
  logic [3:0]  reg_limit = 4'd1;

  rsp_t        awaited_rsp [$];
  plan_row_t   directed_plan [$];
  logic [47:0] pool_addr [4];
  logic [7:0]  pool_type [4];
  bit          idle_en = 1'b1;
  bit          sending = 1'b0;
  int          gap_pct = 15;
  int          stall_pct = 8;
  int          remove_pct = 40;
  int          stall_left = 0;
  int          items = 0;
  int          results = 0;
  int          faults = 0;
  int          outcome_seen [4] = '{default: 0};

  timeslot_admission_queue #(.QUEUE_DEPTH(DEPTH)) uut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic longint unsigned to_ticks(longint unsigned us);
    return (us * 64'd32768) / 64'd1000000;
  endfunction

  function automatic req_t make_req(logic op, logic [47:0] addr, logic [7:0] atype,
                                    logic [31:0] delay, logic [23:0] tick, logic [31:0] win,
                                    logic [31:0] slot, logic [31:0] seed);
    req_t r;
    r.req_type = op;
    r.peer_addr = addr;
    r.peer_addr_type = atype;
    r.delay_us = delay;
    r.ref_tick = tick;
    r.window_us = win;
    r.slot_len_us = slot;
    r.seed_in = seed;
    return r;
  endfunction

  // Applies one request to the queue model and returns the response it should produce.
  function automatic rsp_t apply_request(req_t r);
    rsp_t        res;
    entry_t      tail;
    logic [55:0] peer;
    logic [23:0] start;
    logic [23:0] spacing;
    int          same;
    res = '0;
    res.status = STATUS_OK;
    res.seed_out = r.seed_in;
    if (r.req_type == REQ_APPEND) begin
      peer = {r.peer_addr_type, r.peer_addr};
      start = 24'(64'(r.ref_tick) + to_ticks(64'(r.delay_us) + 64'(reg_offset)));
      if (occupancy >= DEPTH) begin
        res.status = STATUS_FULL;
      end else if (occupancy != 0) begin
        same = 0;
        for (int k = 0; k < occupancy; k++)
          if (slots[(head_pos + k) % DEPTH].peer == peer) same++;
        tail = slots[(head_pos + occupancy - 1) % DEPTH];
        spacing = start - tail.start;
        if (same >= int'(reg_limit))
          res.status = STATUS_PEER_LIMIT;
        else if (64'(spacing) < to_ticks(64'(tail.slot_len) + 64'(reg_gap)))
          res.status = STATUS_TOO_CLOSE;
      end
      if (res.status == STATUS_OK) begin
        slots[(head_pos + occupancy) % DEPTH] = '{start: start, slot_len: r.slot_len_us,
                                                   window_len: r.window_us, peer: peer,
                                                   seed: r.seed_in + 32'd1};
        occupancy++;
        res.seed_out = r.seed_in + 32'd1;
      end
    end else if (occupancy != 0) begin
      head_pos = (head_pos + 1) % DEPTH;
      occupancy--;
    end
    if (occupancy != 0) begin
      res.head_valid = 1'b1;
      res.head_start = slots[head_pos].start;
      res.head_slot_len = slots[head_pos].slot_len;
      res.head_window_len = slots[head_pos].window_len;
      res.head_peer_addr = slots[head_pos].peer[47:0];
      res.head_peer_type = slots[head_pos].peer[55:48];
      res.head_seed = slots[head_pos].seed;
    end
    return res;
  endfunction

  // Most appends are placed just after the tail slot so that they are admitted; a quarter
  // fall slightly short of the required spacing.
  function automatic req_t next_request();
    entry_t      tail;
    longint      need;
    longint      target;
    longint      delay;
    int          p;
    logic [47:0] addr;
    logic [7:0]  atype;
    if ($urandom_range(0, 99) < 12)
      return make_req(1'($urandom), 48'({$urandom, $urandom}), 8'($urandom), $urandom,
                      24'($urandom), $urandom, $urandom, $urandom);
    if ($urandom_range(0, 99) < remove_pct)
      return make_req(REQ_REMOVE, 48'({$urandom, $urandom}), 8'($urandom), $urandom,
                      24'($urandom), $urandom, $urandom, $urandom);
    p = $urandom_range(0, 3);
    addr = pool_addr[p];
    atype = pool_type[p];
    case ($urandom_range(0, 9))
      0: atype ^= 8'(1 << $urandom_range(0, 7));
      1: addr ^= 48'(1) << $urandom_range(0, 47);
      default: ;
    endcase
    if (occupancy == 0 || occupancy >= DEPTH)
      return make_req(REQ_APPEND, addr, atype, $urandom_range(0, 3000000), 24'($urandom),
                      $urandom, $urandom_range(0, 60000), $urandom);
    tail = slots[(head_pos + occupancy - 1) % DEPTH];
    need = longint'(tail.slot_len) + longint'(reg_gap);
    if ($urandom_range(0, 3) == 0)
      target = need - longint'($urandom_range(1, 300));
    else
      target = need + longint'($urandom_range(0, 30000));
    delay = target - longint'(reg_offset);
    if (delay < 0) delay = 0;
    if (delay > longint'(32'hFFFF_FFFF)) delay = longint'(32'hFFFF_FFFF);
    return make_req(REQ_APPEND, addr, atype, 32'(delay), tail.start, $urandom,
                    $urandom_range(0, 60000), $urandom);
  endfunction

  function automatic void compare_result(rsp_t got, rsp_t want);
    string diff;
    diff = "";
    if (got.status !== want.status) diff = {diff, " status"};
    if (got.seed_out !== want.seed_out) diff = {diff, " seed_out"};
    if (got.head_valid !== want.head_valid) diff = {diff, " head_valid"};
    if (got.head_start !== want.head_start) diff = {diff, " head_start"};
    if (got.head_slot_len !== want.head_slot_len) diff = {diff, " head_slot_len"};
    if (got.head_window_len !== want.head_window_len) diff = {diff, " head_window_len"};
    if (got.head_peer_addr !== want.head_peer_addr) diff = {diff, " head_peer_addr"};
    if (got.head_peer_type !== want.head_peer_type) diff = {diff, " head_peer_type"};
    if (got.head_seed !== want.head_seed) diff = {diff, " head_seed"};
    if (diff != "") begin
      faults++;
      if (faults <= 10)
        $display("Response %0d differs in%s: expected %p, got %p", results, diff, want, got);
    end
  endfunction

  task automatic add_row(req_t r, bit typed, rsp_t want);
    directed_plan.push_back('{stim: r, typed: typed, want: want});
  endtask

  task automatic hold_sender();
    if (sending) begin
      req_valid <= 1'b0;
      sending = 1'b0;
    end
  endtask

  task automatic submit(req_t r, bit typed, rsp_t want);
    rsp_t predicted;
    req <= r;
    if (!sending) begin
      req_valid <= 1'b1;
      sending = 1'b1;
    end
    @(posedge clk);
    while (req_stall) @(posedge clk);
    predicted = apply_request(r);
    awaited_rsp.push_back(typed ? want : predicted);
    items++;
    if (idle_en && $urandom_range(0, 99) < gap_pct) begin
      hold_sender();
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    while (awaited_rsp.size() != 0) @(posedge clk);
  endtask

  // Writes every register, plus the unused index, which the block must ignore.
  task automatic configure(logic [23:0] off, logic [23:0] gap, logic [23:0] lim);
    logic [CFG_IDX_W-1:0] idx [4];
    logic [23:0]          val [4];
    idx = '{CFG_RANGING_OFFSET, CFG_MIN_GAP, CFG_PEER_LIMIT, CFG_SPARE};
    val = '{off, gap, lim, 24'($urandom)};
    for (int k = 0; k < 4; k++) begin
      cfg_index <= idx[k];
      cfg_data <= val[k];
      cfg_valid <= 1'b1;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      case (idx[k])
        CFG_RANGING_OFFSET: reg_offset = val[k];
        CFG_MIN_GAP: reg_gap = val[k];
        CFG_PEER_LIMIT: reg_limit = val[k][3:0];
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (idle_en && stall_left > 0) begin
      rsp_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (idle_en && $urandom_range(0, 99) < stall_pct) begin
      rsp_stall <= 1'b1;
      stall_left <= $urandom_range(0, 18);
    end else begin
      rsp_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      results++;
      if (awaited_rsp.size() == 0) begin
        faults++;
        if (faults <= 10) $display("Response with no request outstanding: %p", rsp);
      end else begin
        outcome_seen[awaited_rsp[0].status]++;
        compare_result(rsp, awaited_rsp.pop_front());
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("No transaction for %0d cycles; the run is abandoned.", QUIET_LIMIT);
    $display("FAILURE");
    $finish;
  end

  initial begin : stimulus
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Registers keep their reset values for the directed table.
    add_row(make_req(REQ_REMOVE, '0, '0, '0, '0, '0, '0, 32'hFFFF_FFFF), 1'b1,
            '{seed_out: 32'hFFFF_FFFF, default: '0});
    add_row(make_req(REQ_APPEND, '0, '0, '0, '0, '0, '0, 32'hFFFF_FFFF), 1'b1,
            '{head_valid: 1'b1, default: '0});
    add_row(make_req(REQ_APPEND, '0, '0, '0, '0, '0, '0, 32'h1234_5678), 1'b1,
            '{status: STATUS_PEER_LIMIT, seed_out: 32'h1234_5678, head_valid: 1'b1,
              default: '0});
    add_row(make_req(REQ_APPEND, '0, 8'hFF, 32'hFFFF_FFFF, 24'hFF_FFFF, 32'hFFFF_FFFF,
                     32'hFFFF_FFFF, '0), 1'b0, '0);
    add_row(make_req(REQ_APPEND, 48'hFFFF_FFFF_FFFF, '0, '0, '0, '0, '0, 32'd5), 1'b0, '0);
    add_row(make_req(REQ_REMOVE, '0, '0, '0, '0, '0, '0, 32'hA5A5_A5A5), 1'b0, '0);
    add_row(make_req(REQ_REMOVE, '0, '0, '0, '0, '0, '0, '0), 1'b0, '0);
    add_row(make_req(REQ_REMOVE, '0, '0, '0, '0, '0, '0, 32'h5A5A_5A5A), 1'b1,
            '{seed_out: 32'h5A5A_5A5A, default: '0});
    for (int k = 0; k < DEPTH; k++)
      add_row(make_req(REQ_APPEND, 48'(k + 1), 8'(k + 1), 32'(1000000 * (k + 1)), '0,
                       32'(5 + k), '0, 32'(9 + k)), 1'b0, '0);
    add_row(make_req(REQ_APPEND, 48'hABCD, 8'd3, '0, '0, '0, '0, 32'hFFFF_FFFF), 1'b1,
            '{status: STATUS_FULL, seed_out: 32'hFFFF_FFFF, head_valid: 1'b1,
              head_start: 24'h00_8000, head_window_len: 32'd5, head_peer_addr: 48'h1,
              head_peer_type: 8'h1, head_seed: 32'd10, default: '0});
    for (int k = 0; k < DEPTH; k++)
      add_row(make_req(REQ_REMOVE, '0, '0, '0, '0, '0, '0, $urandom), 1'b0, '0);

    foreach (directed_plan[i])
      submit(directed_plan[i].stim, directed_plan[i].typed, directed_plan[i].want);

    for (int ph = 0; ph < PHASES; ph++) begin
      hold_sender();
      wait_drained();
      case (ph)
        0: configure(24'd0, 24'd0, 24'd8);
        1: configure(24'hFF_FFFF, 24'hFF_FFFF, {20'hF_FFFF, 4'd1});
        2: configure(24'($urandom), 24'($urandom_range(0, 5000)), 24'd2);
        3: configure(24'd0, 24'd0, 24'd0);
        4: configure(24'($urandom), 24'($urandom), 24'd15);
        5: configure(24'($urandom_range(0, 100000)), 24'($urandom_range(0, 20000)),
                     24'($urandom_range(1, 8)));
        default: configure(24'($urandom_range(0, 2000)), 24'($urandom_range(0, 2000)), 24'd4);
      endcase
      idle_en = (ph != PHASES - 1);
      for (int k = 0; k < 4; k++) begin
        pool_addr[k] = 48'({$urandom, $urandom});
        pool_type[k] = 8'($urandom);
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 40 == 0) begin
          remove_pct = 20 * $urandom_range(1, 3);
          gap_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 30);
          stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(3, 15);
        end
        submit(next_request(), 1'b0, '0);
      end
    end

    hold_sender();
    wait_drained();
    repeat (25) @(posedge clk);
    if (awaited_rsp.size() != 0) faults++;
    $display("Sent %0d requests under %0d register settings and checked %0d responses.",
             items, PHASES + 1, results);
    $display("Outcomes: %0d ok, %0d full, %0d peer limit, %0d too close; %0d faults.",
             outcome_seen[STATUS_OK], outcome_seen[STATUS_FULL],
             outcome_seen[STATUS_PEER_LIMIT], outcome_seen[STATUS_TOO_CLOSE], faults);
    if (faults == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
